[rtl/core/clcp_pkg.sv]
package clcp_pkg;
  localparam int unsigned BufDepth = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned LenW = 7;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [3:0] ERR_EMPTY    = 4'd0;
  localparam logic [3:0] ERR_NO_COLON = 4'd1;
  localparam logic [3:0] ERR_INDEX    = 4'd2;
  localparam logic [3:0] ERR_HDR_COL  = 4'd3;
  localparam logic [3:0] ERR_LINES    = 4'd4;
  localparam logic [3:0] ERR_HEIGHT   = 4'd5;
  localparam logic [3:0] ERR_TEXT     = 4'd6;
  localparam logic [3:0] ERR_COLOR    = 4'd7;
  localparam logic [3:0] ERR_OVERFLOW = 4'd8;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] row_index;
    logic [15:0] row_count;
    logic [15:0] glyph_height;
    logic [31:0] color;
    logic [7:0]  text_char;
    logic [3:0]  error_code;
    logic        last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction
endpackage

[rtl/core/colon_line_command_parser_unit.sv]
// Channel   | Ports                                   | Dir
// in        | in_valid/in_ready, in_rx_byte           | in
// out       | out_valid/out_ready, out_kind .. last   | out
// cfg       | cfg_we, cfg_line_capacity               | in
//
// A non-LF word is taken while idle and, unless it is a CR or overflows the
// line, written to the store. A newline runs a sequencer over the line store,
// one byte read per cycle through the registered store port: length scan,
// colon scans, number passes, then one text char per cycle as out is free.
// Reset is synchronous: length 0, capacity 64; store contents are undefined.
// in_ready is low while a line is being parsed or a result waits.
module colon_line_command_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_row_index,
  output logic [15:0] out_row_count,
  output logic [15:0] out_glyph_height,
  output logic [31:0] out_color,
  output logic [7:0]  out_text_char,
  output logic [3:0]  out_error_code,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_line_capacity
);
  import clcp_pkg::*;

  // Sequencer phases. Each scan issues a read of address addr and sees
  // the data in rd_r in the next cycle (rd_v_r marks that).
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LEN   = 10'b0000000010, // find effective length (stop at zero byte)
    S_FC    = 10'b0000000100, // first colon
    S_IDX   = 10'b0000001000, // parse index over [0,fc)
    S_SC    = 10'b0000010000, // header: second colon
    S_NUMA  = 10'b0000100000, // parse a number over [a,b)
    S_NUMB  = 10'b0001000000, // header: font height; text: color
    S_LC    = 10'b0010000000, // text: last colon, scanning backward
    S_TEXT  = 10'b0100000000, // emit characters
    S_OUT   = 10'b1000000000  // single result waiting
  } state_t;

  state_t      st_r, st_nxt;
  logic [7:0]  mem [BufDepth];
  logic [7:0]  rd_r;
  logic [LenW-1:0] len_r, len_nxt;     // bytes stored
  logic [LenW-1:0] elen_r, elen_nxt;   // effective line length
  logic [LenW-1:0] fc_r, fc_nxt, sc_r, sc_nxt;
  logic [LenW-1:0] pos_r, pos_nxt;     // position whose data is in rd_r
  logic [LenW-1:0] addr;               // read address this cycle
  logic        rd_v_r, rd_v_nxt;
  logic [6:0]  cap_r;
  logic [LenW-1:0] cap_eff;
  logic [15:0] idx_r, idx_nxt, nl_r, nl_nxt;
  logic [31:0] col_r, col_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  result_t     res_r, res_nxt;

  logic        acc_clr, acc_step, acc_sat, acc_bad;
  logic [31:0] acc_val;

  clcp_dec_acc u_acc (
    .clk(clk), .clr(acc_clr), .step(acc_step), .ch(rd_r), .sat(acc_sat),
    .val(acc_val), .bad(acc_bad)
  );

  assign cap_eff = (cap_r == 7'd0) ? 7'd1 :
                   (cap_r > 7'(BufDepth)) ? 7'(BufDepth) : cap_r;
  assign in_ready = (st_r == S_IDLE);

  logic wr_en;
  assign wr_en = in_valid && in_ready && (in_rx_byte != CH_CR) &&
                 (in_rx_byte != CH_LF) && !(len_r + 7'd1 >= cap_eff);

  always_ff @(posedge clk) begin
    if (wr_en) mem[len_r[AddrW-1:0]] <= in_rx_byte;
    rd_r <= mem[addr[AddrW-1:0]];
  end

  function automatic result_t mk_err(input logic [3:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.last = 1'b1;
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r; len_nxt = len_r; elen_nxt = elen_r; fc_nxt = fc_r;
    sc_nxt = sc_r; pos_nxt = pos_r; rd_v_nxt = 1'b0; idx_nxt = idx_r;
    nl_nxt = nl_r; col_nxt = col_r; cnt_nxt = cnt_r; res_nxt = res_r;
    addr = pos_r; acc_clr = 1'b0; acc_step = 1'b0;
    acc_sat = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_rx_byte == CH_LF) begin
            st_nxt = S_LEN; addr = '0; pos_nxt = '0; rd_v_nxt = 1'b1;
            elen_nxt = '0;
          end else if (in_rx_byte != CH_CR) begin
            if (len_r + 7'd1 >= cap_eff) begin
              len_nxt = '0; res_nxt = mk_err(ERR_OVERFLOW); st_nxt = S_OUT;
            end else begin
              len_nxt = len_r + 7'd1;
            end
          end
        end
      end
      S_LEN: begin
        if (pos_r >= len_r || rd_r == 8'd0) begin
          elen_nxt = pos_r;
          if (pos_r == '0) begin
            res_nxt = mk_err(ERR_EMPTY); st_nxt = S_OUT;
          end else begin
            st_nxt = S_FC; addr = '0; pos_nxt = '0; rd_v_nxt = 1'b1;
          end
        end else begin
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_FC: begin
        if (pos_r >= elen_r) begin
          res_nxt = mk_err(ERR_NO_COLON); st_nxt = S_OUT;
        end else if (rd_r == CH_COLON) begin
          fc_nxt = pos_r; st_nxt = S_IDX; acc_clr = 1'b1;
          addr = '0; pos_nxt = '0; rd_v_nxt = 1'b1;
        end else begin
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_IDX: begin
        if (pos_r >= fc_r) begin
          if (acc_bad) begin
            res_nxt = mk_err(ERR_INDEX); st_nxt = S_OUT;
          end else begin
            idx_nxt = acc_val[15:0];
            addr = fc_r + 7'd1; pos_nxt = fc_r + 7'd1; rd_v_nxt = 1'b1;
            if (acc_val[15:0] == 16'd0) begin
              st_nxt = S_SC;
            end else begin
              // backward scan from elen-1 down to fc+1
              st_nxt = S_LC; sc_nxt = elen_r;
              addr = elen_r - 7'd1; pos_nxt = elen_r - 7'd1;
            end
          end
        end else begin
          acc_step = 1'b1;
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_SC: begin
        if (pos_r >= elen_r) begin
          res_nxt = mk_err(ERR_HDR_COL); st_nxt = S_OUT;
        end else if (rd_r == CH_COLON) begin
          sc_nxt = pos_r; st_nxt = S_NUMA; acc_clr = 1'b1;
          addr = fc_r + 7'd1; pos_nxt = fc_r + 7'd1; rd_v_nxt = 1'b1;
        end else begin
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_NUMA: begin
        if (pos_r >= sc_r) begin
          if (acc_bad) begin
            res_nxt = mk_err(ERR_LINES); st_nxt = S_OUT;
          end else begin
            nl_nxt = acc_val[15:0]; acc_clr = 1'b1; st_nxt = S_NUMB;
            addr = sc_r + 7'd1; pos_nxt = sc_r + 7'd1; rd_v_nxt = 1'b1;
          end
        end else begin
          acc_step = 1'b1;
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_NUMB: begin
        acc_sat = (idx_r != 16'd0);
        if (pos_r >= elen_r) begin
          if (acc_bad) begin
            res_nxt = mk_err((idx_r == 16'd0) ? ERR_HEIGHT : ERR_COLOR);
            st_nxt = S_OUT;
          end else if (idx_r == 16'd0) begin
            res_nxt = '0; res_nxt.kind = KIND_HEADER;
            res_nxt.row_count = nl_r;
            res_nxt.glyph_height = acc_val[15:0];
            res_nxt.last = 1'b1; st_nxt = S_OUT;
          end else begin
            col_nxt = acc_val; cnt_nxt = '0; st_nxt = S_TEXT;
            addr = fc_r + 7'd1; pos_nxt = fc_r + 7'd1; rd_v_nxt = 1'b1;
          end
        end else begin
          acc_step = 1'b1;
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_LC: begin
        if (pos_r <= fc_r + 7'd1 || pos_r >= elen_r) begin
          res_nxt = mk_err(ERR_TEXT); st_nxt = S_OUT;
        end else if (rd_r == CH_COLON) begin
          sc_nxt = pos_r; acc_clr = 1'b1; st_nxt = S_NUMB;
          addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
        end else begin
          addr = pos_r - 7'd1; pos_nxt = pos_r - 7'd1; rd_v_nxt = 1'b1;
        end
      end
      S_TEXT: begin
        // rd_r holds char at pos_r; present it, advance when taken
        if (!rd_v_r || (out_valid && out_ready)) begin
          if (rd_v_r) cnt_nxt = cnt_r + 7'd1;
          if (rd_v_r && (pos_r + 7'd1 == sc_r || cnt_r == 7'd63)) begin
            st_nxt = S_IDLE; len_nxt = '0;
          end else if (rd_v_r) begin
            addr = pos_r + 7'd1; pos_nxt = pos_r + 7'd1; rd_v_nxt = 1'b1;
          end else begin
            rd_v_nxt = 1'b1;
          end
        end else begin
          rd_v_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          st_nxt = S_IDLE; len_nxt = '0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; len_r <= '0; cap_r <= 7'd64; rd_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; len_r <= len_nxt; rd_v_r <= rd_v_nxt;
      if (cfg_we) cap_r <= cfg_line_capacity;
    end
    elen_r <= elen_nxt; fc_r <= fc_nxt; sc_r <= sc_nxt; pos_r <= pos_nxt;
    idx_r <= idx_nxt; nl_r <= nl_nxt; col_r <= col_nxt; cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  // Text results are built straight from the read register.
  logic tlast;
  assign tlast = (pos_r + 7'd1 == sc_r) || (cnt_r == 7'd63);
  assign out_valid = (st_r == S_OUT) || (st_r == S_TEXT && rd_v_r);
  always_comb begin
    if (st_r == S_TEXT) begin
      out_kind = KIND_TEXT; out_row_index = idx_r; out_row_count = '0;
      out_glyph_height = '0; out_color = col_r; out_text_char = rd_r;
      out_error_code = '0; out_last = tlast;
    end else begin
      out_kind = res_r.kind; out_row_index = res_r.row_index;
      out_row_count = res_r.row_count;
      out_glyph_height = res_r.glyph_height; out_color = res_r.color;
      out_text_char = res_r.text_char; out_error_code = res_r.error_code;
      out_last = res_r.last;
    end
  end
endmodule

[rtl/core/clcp_dec_acc.sv]
// Decimal accumulator: one digit per step, 16-bit strict or 32-bit saturating.
module clcp_dec_acc (
  input  logic        clk,
  input  logic        clr,
  input  logic        step,
  input  logic [7:0]  ch,
  input  logic        sat,
  output logic [31:0] val,
  output logic        bad
);
  import clcp_pkg::*;

  logic [31:0] val_r, val_nxt;
  logic        bad_r, bad_nxt, any_r, any_nxt;
  logic [35:0] prod;

  assign prod = {4'd0, val_r} * 36'd10 + {32'd0, ch[3:0]};

  always_comb begin
    val_nxt = val_r;
    bad_nxt = bad_r;
    any_nxt = any_r;
    if (clr) begin
      val_nxt = '0;
      bad_nxt = 1'b0;
      any_nxt = 1'b0;
    end else if (step) begin
      any_nxt = 1'b1;
      if (!is_digit(ch)) begin
        bad_nxt = 1'b1;
      end else if (sat) begin
        val_nxt = (prod > 36'hFFFFFFFF) ? 32'hFFFFFFFF : prod[31:0];
      end else if (prod > 36'd65535) begin
        bad_nxt = 1'b1;
      end else begin
        val_nxt = prod[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    bad_r <= bad_nxt;
    any_r <= any_nxt;
  end

  assign val = val_r;
  assign bad = bad_r | ~any_r;
endmodule

[test/clcp_checker.sv]
module clcp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_row_index,
  input  logic [15:0] out_row_count,
  input  logic [15:0] out_glyph_height,
  input  logic [31:0] out_color,
  input  logic [7:0]  out_text_char,
  input  logic [3:0]  out_error_code,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_line_capacity,
  output int          fail_count,
  output int          results_seen,
  output int          results_pending
);
  import clcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxChars = 64;

  logic [7:0] line_buf [BufDepth];
  int         line_len;
  int         capacity;
  result_t    expected_q [$];

  assign results_pending = expected_q.size();

  function automatic void push_result(logic [1:0] k, logic [15:0] idx, logic [15:0] nl,
                                      logic [15:0] fh, logic [31:0] col, logic [7:0] ch,
                                      logic [3:0] err, logic lst);
    result_t r;
    r.kind = k; r.row_index = idx; r.row_count = nl; r.glyph_height = fh;
    r.color = col; r.text_char = ch; r.error_code = err; r.last = lst;
    expected_q.push_back(r);
  endfunction

  function automatic void push_error(logic [3:0] err);
    push_result(KIND_ERROR, '0, '0, '0, '0, '0, err, 1'b1);
  endfunction

  // strict decimal over line_buf[a..b); saturate or reject above lim
  function automatic bit dec_field(int a, int b, longint unsigned lim, bit sat,
                                   output longint unsigned val);
    longint unsigned v;
    v = 0;
    val = 0;
    if (a >= b) return 0;
    for (int i = a; i < b; i++) begin
      if (line_buf[i] < CH_ZERO || line_buf[i] > CH_NINE) return 0;
      v = v * 10 + (line_buf[i] - CH_ZERO);
      if (v > lim) begin
        if (!sat) return 0;
        v = lim + 1;
      end
    end
    val = (v > lim) ? lim : v;
    return 1;
  endfunction

  function automatic void eval_line();
    int len, fc, sc, n;
    longint unsigned idx, a, b;
    len = 0;
    while (len < line_len && len < BufDepth && line_buf[len] != 8'h00) len++;
    if (len == 0) begin push_error(ERR_EMPTY); return; end
    fc = 0;
    while (fc < len && line_buf[fc] != CH_COLON) fc++;
    if (fc == len) begin push_error(ERR_NO_COLON); return; end
    if (!dec_field(0, fc, 65535, 0, idx)) begin push_error(ERR_INDEX); return; end
    if (idx == 0) begin
      sc = fc + 1;
      while (sc < len && line_buf[sc] != CH_COLON) sc++;
      if (sc >= len) begin push_error(ERR_HDR_COL); return; end
      if (!dec_field(fc + 1, sc, 65535, 0, a)) begin push_error(ERR_LINES); return; end
      if (!dec_field(sc + 1, len, 65535, 0, b)) begin push_error(ERR_HEIGHT); return; end
      push_result(KIND_HEADER, '0, a[15:0], b[15:0], '0, '0, '0, 1'b1);
      return;
    end
    // text splits at the last colon past the first one
    sc = len;
    for (int i = len; i > fc + 1; i--) begin
      if (line_buf[i-1] == CH_COLON) begin sc = i - 1; break; end
    end
    if (sc == len || sc == fc + 1) begin push_error(ERR_TEXT); return; end
    if (!dec_field(sc + 1, len, 64'hFFFF_FFFF, 1, a)) begin push_error(ERR_COLOR); return; end
    n = 0;
    for (int i = fc + 1; i < sc && n < MaxChars; i++) begin
      push_result(KIND_TEXT, idx[15:0], '0, '0, a[31:0], line_buf[i], '0,
                  (i + 1 == sc) || (n + 1 == MaxChars));
      n++;
    end
  endfunction

  function automatic void take_word(logic [7:0] c);
    int cap;
    cap = capacity;
    if (cap < 1) cap = 1;
    if (cap > BufDepth) cap = BufDepth;
    if (c == CH_CR) return;
    if (c == CH_LF) begin
      eval_line();
      line_len = 0;
      return;
    end
    if (line_len + 1 >= cap || line_len >= BufDepth) begin
      line_len = 0;
      push_error(ERR_OVERFLOW);
      return;
    end
    line_buf[line_len] = c;
    line_len++;
  endfunction

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      line_len = 0;
      capacity = 64;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) capacity = cfg_line_capacity;
      if (in_valid && in_ready) take_word(in_rx_byte);
      if (out_valid && out_ready) begin
        got = '{out_kind, out_row_index, out_row_count, out_glyph_height,
                out_color, out_text_char, out_error_code, out_last};
        results_seen++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind || got.row_index !== want.row_index ||
              got.row_count !== want.row_count ||
              got.glyph_height !== want.glyph_height || got.color !== want.color ||
              got.text_char !== want.text_char || got.error_code !== want.error_code ||
              got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: exp %p got %p", want, got);
          end
        end
      end
    end
  end
endmodule

[test/tb_top.sv]
module tb_top;
  import clcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid, out_ready;
  logic [1:0]  out_kind;
  logic [15:0] out_row_index, out_row_count, out_glyph_height;
  logic [31:0] out_color;
  logic [7:0]  out_text_char;
  logic [3:0]  out_error_code;
  logic        out_last;
  logic        cfg_we;
  logic [6:0]  cfg_line_capacity;

  int fail_count, results_seen, results_pending;

  // flow-control knobs, percent of cycles spent idle / stalled
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;       // long receiver hold-off, in cycles
  int words_sent;
  int quiet_cycles;

  logic [7:0] line_q [$];

  localparam int WatchdogLimit = 20000;

  always #2 clk = ~clk;

  colon_line_command_parser_unit u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_rx_byte,
    .out_valid, .out_ready, .out_kind, .out_row_index, .out_row_count,
    .out_glyph_height, .out_color, .out_text_char, .out_error_code, .out_last,
    .cfg_we, .cfg_line_capacity
  );

  clcp_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_rx_byte,
    .out_valid, .out_ready, .out_kind, .out_row_index, .out_row_count,
    .out_glyph_height, .out_color, .out_text_char, .out_error_code, .out_last,
    .cfg_we, .cfg_line_capacity, .fail_count, .results_seen, .results_pending
  );

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles with no word moving on any port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one word; called and returning at a falling edge, valid left high
  task automatic send_word(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_word(line_q[i]);
    line_q.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_str(string s);
    add_str(s);
    send_line();
  endtask

  // sender pause until every result is back, plus slack for the sequencer
  task automatic drain();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (450) @(negedge clk);
  endtask

  task automatic write_capacity(logic [6:0] v);
    cfg_we            <= 1'b1;
    cfg_line_capacity <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // number text: mostly in range, sometimes at or past the limits, sometimes junk
  function automatic string num_text(bit wide);
    case ($urandom_range(11))
      0: return "65535";
      1: return "65536";
      2: return wide ? "4294967295" : "99999";
      3: return wide ? "123456789012" : "0";
      4: return "";
      5: return "+7";
      6: return " 3";
      7: return "1a";
      default: return $sformatf("%0d", $urandom_range(wide ? 100000 : 999));
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(9) == 0) return CH_COLON;
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  task automatic build_line();
    int n;
    case ($urandom_range(9))
      0, 1, 2: begin
        add_str(($urandom_range(5) == 0) ? "00" : "0");
        add_str(":"); add_str(num_text(0));
        if ($urandom_range(7) != 0) begin add_str(":"); add_str(num_text(0)); end
      end
      3, 4, 5, 6, 8: begin
        add_str(($urandom_range(4) == 0) ? num_text(0) :
                $sformatf("%0d", $urandom_range(1, 65535)));
        add_str(":");
        n = $urandom_range(0, 18);
        for (int i = 0; i < n; i++) line_q.push_back(text_byte());
        if ($urandom_range(7) != 0) add_str(":");
        add_str(num_text(1));
      end
      7: begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) line_q.push_back(8'($urandom_range(255)));
      end
      default: begin
        n = $urandom_range(40, 70);
        add_str("9:");
        for (int i = 0; i < n; i++) line_q.push_back(text_byte());
        add_str(":1");
      end
    endcase
    // broken lines: a stray byte, a CR or a NUL somewhere
    if (line_q.size() > 0 && $urandom_range(5) == 0)
      line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
    if (line_q.size() > 0 && $urandom_range(7) == 0)
      line_q.insert($urandom_range(line_q.size()), CH_CR);
    if (line_q.size() > 0 && $urandom_range(15) == 0)
      line_q.insert($urandom_range(line_q.size()), 8'h00);
    line_q.push_back(CH_LF);
  endtask

  task automatic random_lines(int count);
    repeat (count) begin
      build_line();
      send_line();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_line_capacity = 7'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    words_sent = 0;
    quiet_cycles = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines at reset capacity
    send_str("0:480:16\n");
    send_str("0:65535:0\n");
    send_str("5:hello:255\r\n");
    send_str("\n");
    send_str("abc\n");
    send_str("x:1\n");
    send_str("65536:a:1\n");
    send_str("0:12\n");
    send_str("0:a:1\n");
    send_str("0:1:b\n");
    send_str("0:1:\n");
    send_str("0:70000:1\n");
    send_str("3:abc\n");
    send_str("3::5\n");
    send_str("3:a:b:99999999999\n");
    send_str("65535:\xff\x01:4294967295\n");
    send_str("3:a:x\n");
    add_str("7:ab"); line_q.push_back(8'h00); add_str(":1\n"); send_line();
    repeat (70) line_q.push_back("a");
    line_q.push_back(CH_LF);
    send_line();
    drain();

    // capacity extremes: every stored byte overflows
    write_capacity(7'd0);
    random_lines(1);
    drain();
    write_capacity(7'd1);
    send_idle_pct = 88;
    random_lines(1);
    drain();

    // past the buffer depth acts as full depth
    write_capacity(7'd127);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    random_lines(2);
    drain();

    write_capacity(7'd10);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    random_lines(2);
    drain();

    // receiver holds off while sender keeps pushing: input must back up
    write_capacity(7'd64);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 600;
    random_lines(2);
    drain();

    $display("sent %0d words, checked %0d results", words_sent, results_seen);
    $display("capacities 64/0/1/127/10/64, idle and stall mixes, long output hold-off");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

[colon_line_command_parser_unit.f]
rtl/core/clcp_pkg.sv
rtl/core/clcp_dec_acc.sv
rtl/core/colon_line_command_parser_unit.sv
test/clcp_checker.sv
test/tb_top.sv
